// File: sv/cws_pkg.sv
// Shared types, codes and constants for the comment and whitespace skipper.
`timescale 1ns / 1ps
`default_nettype none

package cws_pkg;

    // Default sizes of the run counters and position counters.
    localparam int RUN_BITS_DEF    = 8;
    localparam int LINE_BITS_DEF   = 20;
    localparam int COLUMN_BITS_DEF = 16;

    // Widths of the position fields in a result beat.
    localparam int LINE_OUT_W   = 20;
    localparam int COLUMN_OUT_W = 16;

    // Character codes the skipper reacts to.
    localparam logic [7:0] CH_AT  = 8'h40;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_END = 8'h00;

    // Scan mode, one-hot.
    typedef enum logic [4:0] {
        MODE_OUTER = 5'b00001,
        MODE_OPEN  = 5'b00010,
        MODE_LINE  = 5'b00100,
        MODE_BLOCK = 5'b01000,
        MODE_CLOSE = 5'b10000
    } t_mode;

    // Classification of one character.
    typedef enum logic [1:0] {
        KIND_SPACE   = 2'd0,
        KIND_COMMENT = 2'd1,
        KIND_STOP    = 2'd2,
        KIND_PASS    = 2'd3
    } t_kind;

    // Input beat.
    typedef struct packed {
        logic [7:0] char_code;
        logic       scan_active;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        logic [1:0]              kind;
        logic                    at_end_of_text;
        logic                    unterminated;
        logic [LINE_OUT_W-1:0]   line_out;
        logic [COLUMN_OUT_W-1:0] column_out;
    } t_out_beat;

    // Decision of the classifier for one character.
    typedef struct packed {
        t_mode mode;
        t_kind kind;
        logic  eot;
        logic  unterm;
        logic  consume;
    } t_step;

endpackage

`default_nettype wire

// File: sv/cws_classify.sv
// Per-character mode transition and classification logic.
`timescale 1ns / 1ps
`default_nettype none

module cws_classify #(
    parameter int RUN_BITS = cws_pkg::RUN_BITS_DEF
) (
    input  wire cws_pkg::t_mode   i_mode,
    input  wire [RUN_BITS-1:0]    i_open_run,
    input  wire [RUN_BITS-1:0]    i_close_run,
    input  wire [7:0]             i_char,
    input  wire                   i_active,
    output cws_pkg::t_step        o_step,
    output logic [RUN_BITS-1:0]   o_open_run,
    output logic [RUN_BITS-1:0]   o_close_run
);

    localparam logic [RUN_BITS-1:0] RUN_ONE = RUN_BITS'(1);
    localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

    logic is_at;
    logic is_nl;
    logic is_end;
    logic is_space;
    logic do_outer;
    logic do_block;
    logic [RUN_BITS-1:0] open_inc;
    logic [RUN_BITS-1:0] close_inc;

    // Character decode and saturating run increments.
    always_comb begin
        is_at     = (i_char == cws_pkg::CH_AT);
        is_nl     = (i_char == cws_pkg::CH_NL);
        is_end    = (i_char == cws_pkg::CH_END);
        is_space  = i_char inside {cws_pkg::CH_SP, cws_pkg::CH_CR,
                                   cws_pkg::CH_TAB, cws_pkg::CH_NL};
        open_inc  = (i_open_run == RUN_MAX) ? RUN_MAX : i_open_run + RUN_ONE;
        close_inc = (i_close_run == RUN_MAX) ? RUN_MAX : i_close_run + RUN_ONE;
    end

    // The current mode either settles the character itself or hands it on
    // to block or outer handling in the same cycle.
    always_comb begin
        o_step.mode    = i_mode;
        o_step.kind    = cws_pkg::KIND_STOP;
        o_step.eot     = 1'b0;
        o_step.unterm  = 1'b0;
        o_step.consume = 1'b0;
        o_open_run     = i_open_run;
        o_close_run    = i_close_run;
        do_outer       = 1'b0;
        do_block       = 1'b0;

        if (!i_active) begin
            o_step.consume = 1'b1;
            o_step.kind    = cws_pkg::KIND_PASS;
        end else begin
            case (i_mode)
                cws_pkg::MODE_OPEN: begin
                    if (is_at) begin
                        o_open_run     = open_inc;
                        o_step.consume = 1'b1;
                        o_step.kind    = cws_pkg::KIND_COMMENT;
                    end else if (i_open_run == RUN_ONE && !is_nl && !is_end) begin
                        o_step.mode    = cws_pkg::MODE_LINE;
                        o_step.consume = 1'b1;
                        o_step.kind    = cws_pkg::KIND_COMMENT;
                    end else begin
                        do_block = 1'b1;
                    end
                end
                cws_pkg::MODE_LINE: begin
                    if (is_nl || is_end) begin
                        do_outer = 1'b1;
                    end else begin
                        o_step.consume = 1'b1;
                        o_step.kind    = cws_pkg::KIND_COMMENT;
                    end
                end
                cws_pkg::MODE_BLOCK: begin
                    do_block = 1'b1;
                end
                cws_pkg::MODE_CLOSE: begin
                    if (is_at) begin
                        o_close_run    = close_inc;
                        o_step.consume = 1'b1;
                        o_step.kind    = cws_pkg::KIND_COMMENT;
                    end else if (i_close_run >= i_open_run) begin
                        o_open_run  = '0;
                        o_close_run = '0;
                        do_outer    = 1'b1;
                    end else begin
                        o_close_run = '0;
                        do_block    = 1'b1;
                    end
                end
                default: begin
                    do_outer = 1'b1;
                end
            endcase

            // Inside a block comment: end of text is an error, '@' starts a
            // possible closing run.
            if (do_block) begin
                if (is_end) begin
                    o_step.mode   = cws_pkg::MODE_OUTER;
                    o_step.kind   = cws_pkg::KIND_STOP;
                    o_step.eot    = 1'b1;
                    o_step.unterm = 1'b1;
                    o_open_run    = '0;
                    o_close_run   = '0;
                end else if (is_at) begin
                    o_step.mode    = cws_pkg::MODE_CLOSE;
                    o_close_run    = RUN_ONE;
                    o_step.consume = 1'b1;
                    o_step.kind    = cws_pkg::KIND_COMMENT;
                end else begin
                    o_step.mode    = cws_pkg::MODE_BLOCK;
                    o_step.consume = 1'b1;
                    o_step.kind    = cws_pkg::KIND_COMMENT;
                end
            end

            // Outside comments: skip whitespace, open a comment, or stop.
            if (do_outer) begin
                o_step.mode = cws_pkg::MODE_OUTER;
                if (is_space) begin
                    o_step.consume = 1'b1;
                    o_step.kind    = cws_pkg::KIND_SPACE;
                end else if (is_at) begin
                    o_step.mode    = cws_pkg::MODE_OPEN;
                    o_open_run     = RUN_ONE;
                    o_close_run    = '0;
                    o_step.consume = 1'b1;
                    o_step.kind    = cws_pkg::KIND_COMMENT;
                end else begin
                    o_step.kind = cws_pkg::KIND_STOP;
                    o_step.eot  = is_end;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/cws_position.sv
// Saturating line and column counters.
`timescale 1ns / 1ps
`default_nettype none

module cws_position #(
    parameter int LINE_BITS   = cws_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = cws_pkg::COLUMN_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_consume,
    input  wire [7:0]               i_char,
    output logic [LINE_BITS-1:0]    o_line_next,
    output logic [COLUMN_BITS-1:0]  o_column_next
);

    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};

    logic [LINE_BITS-1:0]   r_line;
    logic [LINE_BITS-1:0]   n_line;
    logic [COLUMN_BITS-1:0] r_column;
    logic [COLUMN_BITS-1:0] n_column;

    // For a consumed byte, a newline moves to the next line and column 1; any other nonzero byte moves one column.
    always_comb begin
        n_line   = r_line;
        n_column = r_column;
        if (i_en && i_consume && i_char != cws_pkg::CH_END) begin
            if (i_char == cws_pkg::CH_NL) begin
                if (r_line != LINE_MAX) begin
                    n_line = r_line + LINE_ONE;
                end
                n_column = COL_ONE;
            end else if (r_column != COL_MAX) begin
                n_column = r_column + COL_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line   <= LINE_ONE;
            r_column <= COL_ONE;
        end else begin
            r_line   <= n_line;
            r_column <= n_column;
        end
    end

    assign o_line_next   = n_line;
    assign o_column_next = n_column;

endmodule

`default_nettype wire

// File: sv/comment_whitespace_skipper_unit.sv
// Top level of the comment and whitespace skipper.
// A beat accepted into the input register is classified and written to the result register once that is free.
// Throughput: one beat per cycle unless i_stall holds the result register; each character's
// mode and position update is combinational between the input and result registers.
// Reset (synchronous, active low) empties both registers, returns to outer mode with
// both run counters cleared, and sets line and column to 1.
`timescale 1ns / 1ps
`default_nettype none

module comment_whitespace_skipper_unit #(
    parameter int RUN_BITS    = cws_pkg::RUN_BITS_DEF,
    parameter int LINE_BITS   = cws_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = cws_pkg::COLUMN_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire cws_pkg::t_in_beat i_data,
    output logic                 o_valid,
    input  wire                  i_stall,
    output cws_pkg::t_out_beat   o_data
);

    logic                  r_in_vld;
    cws_pkg::t_in_beat     r_in;
    logic                  r_out_vld;
    cws_pkg::t_out_beat    r_out;
    cws_pkg::t_mode        r_mode;
    logic [RUN_BITS-1:0]   r_open_run;
    logic [RUN_BITS-1:0]   r_close_run;

    cws_pkg::t_step        w_step;
    logic [RUN_BITS-1:0]   n_open_run;
    logic [RUN_BITS-1:0]   n_close_run;
    logic [LINE_BITS-1:0]  w_line;
    logic [COLUMN_BITS-1:0] w_column;
    logic [31:0]           w_line_ext;
    logic [31:0]           w_column_ext;
    cws_pkg::t_out_beat    n_out;

    logic w_out_free;
    logic w_adv;
    logic w_take;

    // Handshake: the input register moves on whenever the result register is free
    // or being emptied in the same cycle.
    assign w_out_free = !r_out_vld || !i_stall;
    assign w_adv      = r_in_vld && w_out_free;
    assign o_stall    = r_in_vld && !w_out_free;
    assign w_take     = i_valid && !o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_take) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_data;
        end
    end

    // Character classification.
    cws_classify #(
        .RUN_BITS(RUN_BITS)
    ) u_classify (
        .i_mode      (r_mode),
        .i_open_run  (r_open_run),
        .i_close_run (r_close_run),
        .i_char      (r_in.char_code),
        .i_active    (r_in.scan_active),
        .o_step      (w_step),
        .o_open_run  (n_open_run),
        .o_close_run (n_close_run)
    );

    // Line and column tracking.
    cws_position #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_position (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_adv),
        .i_consume     (w_step.consume),
        .i_char        (r_in.char_code),
        .o_line_next   (w_line),
        .o_column_next (w_column)
    );

    // Scan state advances with every beat that is classified.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= cws_pkg::MODE_OUTER;
            r_open_run  <= '0;
            r_close_run <= '0;
        end else if (w_adv) begin
            r_mode      <= w_step.mode;
            r_open_run  <= n_open_run;
            r_close_run <= n_close_run;
        end
    end

    // Result beat: positions are masked to the output field widths.
    always_comb begin
        w_line_ext          = 32'(w_line);
        w_column_ext        = 32'(w_column);
        n_out.kind           = w_step.kind;
        n_out.at_end_of_text = w_step.eot;
        n_out.unterminated   = w_step.unterm;
        n_out.line_out       = w_line_ext[cws_pkg::LINE_OUT_W-1:0];
        n_out.column_out     = w_column_ext[cws_pkg::COLUMN_OUT_W-1:0];
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_adv || (r_out_vld && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // The scan mode is always exactly one of the one-hot codes.
    a_mode_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_mode))
        else $error("scan mode is not one-hot");

    // A beat passed to the token scanner leaves mode and runs untouched.
    a_passive_keeps_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in.scan_active) |=>
            (r_mode == $past(r_mode) && r_open_run == $past(r_open_run)
             && r_close_run == $past(r_close_run)))
        else $error("passive beat changed the scan state");

    // An unterminated comment is only reported as a stop on end of text.
    a_unterm_is_eot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.unterminated) |->
            (o_data.at_end_of_text && o_data.kind == cws_pkg::KIND_STOP))
        else $error("unterminated flag without end of text stop");

    // A held input beat is never dropped.
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |=> r_in_vld)
        else $error("input beat lost while stalled");

endmodule

`default_nettype wire
